### hdl/quaternion_rotate_vector_macros.svh
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_macros
// Concurrent assertion shorthands on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ROTATE_VECTOR_MACROS_SVH
`define QUATERNION_ROTATE_VECTOR_MACROS_SVH

// Check cons in the same cycle as ante.
`define QRV_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check cons a fixed number of cycles after ante.
`define QRV_ASSERT_DLY(lbl, ante, dly, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

### hdl/qrv_pkg.sv
// ----------------------------------------------------------------------------
// qrv_pkg
// Shared width rules for the quaternion rotation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package qrv_pkg;

    localparam int MODEL_W = 64;

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    // Matrix entry: sums of two or four products, doubled off-diagonal.
    function automatic int me_width(input int dw);
        return min_int(2 * dw + 3, MODEL_W);
    endfunction

    // Sum of three entry-by-component products.
    function automatic int acc_width(input int dw);
        return min_int(3 * dw + 5, MODEL_W);
    endfunction

    // Accumulator plus rounding offset without overflow.
    function automatic int rnd_width(input int dw, input int fb);
        return min_int(MODEL_W, max_int(acc_width(dw), 2 * fb) + 1);
    endfunction

endpackage

`default_nettype wire

### hdl/quaternion_rotate_vector.sv
// ----------------------------------------------------------------------------
// quaternion_rotate_vector
// Rotates a vector by a fixed-point quaternion through the rotation matrix.
// Throughput: one request per cycle; busy is always low.
// The five stages are the two multiplier ranks, their add trees and the rounding.
// Reset clears the valid pipeline only; data registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quaternion_rotate_vector_macros.svh"

module quaternion_rotate_vector
    import qrv_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] quat_w,
    input  logic signed [DATA_WIDTH-1:0] quat_x,
    input  logic signed [DATA_WIDTH-1:0] quat_y,
    input  logic signed [DATA_WIDTH-1:0] quat_z,
    input  logic signed [DATA_WIDTH-1:0] vec_x,
    input  logic signed [DATA_WIDTH-1:0] vec_y,
    input  logic signed [DATA_WIDTH-1:0] vec_z,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] rot_x,
    output logic signed [DATA_WIDTH-1:0] rot_y,
    output logic signed [DATA_WIDTH-1:0] rot_z,
    output logic                         saturated
);

    localparam int MW           = me_width(DATA_WIDTH);
    localparam int AW           = acc_width(DATA_WIDTH);
    localparam int PIPE_LATENCY = 5;

    localparam logic signed [DATA_WIDTH-1:0] ROT_MAX = {1'b0, {(DATA_WIDTH - 1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] ROT_MIN = ~ROT_MAX;

    logic                         req;
    logic                         mat_valid;
    logic signed [MW-1:0]         mat [9];
    logic signed [DATA_WIDTH-1:0] vec [3];
    logic                         acc_valid;
    logic signed [AW-1:0]         acc [3];
    logic signed [DATA_WIDTH-1:0] rot [3];
    logic                         rail_hit;

    assign busy = 1'b0;
    assign req  = start && !busy;

    qrv_matrix #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_matrix (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (mat_valid),
        .mat       (mat),
        .vec       (vec)
    );

    qrv_apply #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_apply (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .mat       (mat),
        .vec       (vec),
        .out_valid (acc_valid),
        .acc       (acc)
    );

    qrv_round #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_round (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (acc_valid),
        .acc       (acc),
        .out_valid (done),
        .rot       (rot),
        .sat       (saturated)
    );

    assign rot_x = rot[0];
    assign rot_y = rot[1];
    assign rot_z = rot[2];

    assign rail_hit = rot_x == ROT_MAX || rot_x == ROT_MIN
                   || rot_y == ROT_MAX || rot_y == ROT_MIN
                   || rot_z == ROT_MAX || rot_z == ROT_MIN;

    `QRV_ASSERT_DLY(a_req_done, req, PIPE_LATENCY, done, "request not answered in time")
    `QRV_ASSERT_DLY(a_no_spurious, !req, PIPE_LATENCY, !done, "done without request")
    `QRV_ASSERT_IMP(a_sat_clip, done && saturated, rail_hit, "saturated without a clipped value")

endmodule

`default_nettype wire

### hdl/qrv_matrix.sv
// ----------------------------------------------------------------------------
// qrv_matrix
// Stages one and two: ten quaternion products, then the nine matrix entries.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_matrix
    import qrv_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic signed [DATA_WIDTH-1:0]           quat_w,
    input  logic signed [DATA_WIDTH-1:0]           quat_x,
    input  logic signed [DATA_WIDTH-1:0]           quat_y,
    input  logic signed [DATA_WIDTH-1:0]           quat_z,
    input  logic signed [DATA_WIDTH-1:0]           vec_x,
    input  logic signed [DATA_WIDTH-1:0]           vec_y,
    input  logic signed [DATA_WIDTH-1:0]           vec_z,
    output logic                                   out_valid,
    output logic signed [me_width(DATA_WIDTH)-1:0] mat [9],
    output logic signed [DATA_WIDTH-1:0]           vec [3]
);

    localparam int PW = 2 * DATA_WIDTH;
    localparam int MW = me_width(DATA_WIDTH);

    localparam int PWW = 0;
    localparam int PXX = 1;
    localparam int PYY = 2;
    localparam int PZZ = 3;
    localparam int PWX = 4;
    localparam int PWY = 5;
    localparam int PWZ = 6;
    localparam int PXY = 7;
    localparam int PXZ = 8;
    localparam int PYZ = 9;

    logic                  v1_reg;
    logic                  v2_reg;
    logic signed [PW-1:0]  prod_reg [10];
    logic signed [PW-1:0]  prod_next [10];
    logic signed [MW-1:0]  mat_reg [9];
    logic signed [MW-1:0]  mat_next [9];
    logic signed [DATA_WIDTH-1:0] vec1_reg [3];
    logic signed [DATA_WIDTH-1:0] vec2_reg [3];

    always_comb
    begin
        prod_next[PWW] = quat_w * quat_w;
        prod_next[PXX] = quat_x * quat_x;
        prod_next[PYY] = quat_y * quat_y;
        prod_next[PZZ] = quat_z * quat_z;
        prod_next[PWX] = quat_w * quat_x;
        prod_next[PWY] = quat_w * quat_y;
        prod_next[PWZ] = quat_w * quat_z;
        prod_next[PXY] = quat_x * quat_y;
        prod_next[PXZ] = quat_x * quat_z;
        prod_next[PYZ] = quat_y * quat_z;
    end

    // Double the off-diagonal entries by a left shift.
    always_comb
    begin
        mat_next[0] = MW'(prod_reg[PWW]) + MW'(prod_reg[PXX])
                    - MW'(prod_reg[PYY]) - MW'(prod_reg[PZZ]);
        mat_next[1] = (MW'(prod_reg[PXY]) - MW'(prod_reg[PWZ])) <<< 1;
        mat_next[2] = (MW'(prod_reg[PWY]) + MW'(prod_reg[PXZ])) <<< 1;
        mat_next[3] = (MW'(prod_reg[PWZ]) + MW'(prod_reg[PXY])) <<< 1;
        mat_next[4] = MW'(prod_reg[PWW]) - MW'(prod_reg[PXX])
                    + MW'(prod_reg[PYY]) - MW'(prod_reg[PZZ]);
        mat_next[5] = (MW'(prod_reg[PYZ]) - MW'(prod_reg[PWX])) <<< 1;
        mat_next[6] = (MW'(prod_reg[PXZ]) - MW'(prod_reg[PWY])) <<< 1;
        mat_next[7] = (MW'(prod_reg[PYZ]) + MW'(prod_reg[PWX])) <<< 1;
        mat_next[8] = MW'(prod_reg[PWW]) - MW'(prod_reg[PXX])
                    - MW'(prod_reg[PYY]) + MW'(prod_reg[PZZ]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg    <= prod_next;
            vec1_reg[0] <= vec_x;
            vec1_reg[1] <= vec_y;
            vec1_reg[2] <= vec_z;
        end
        if (v1_reg)
        begin
            mat_reg  <= mat_next;
            vec2_reg <= vec1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign mat       = mat_reg;
    assign vec       = vec2_reg;

endmodule

`default_nettype wire

### hdl/qrv_apply.sv
// ----------------------------------------------------------------------------
// qrv_apply
// Stages three and four: nine entry-by-component products, then row sums.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_apply
    import qrv_pkg::*;
#(
    parameter int DATA_WIDTH = 16
)(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic signed [me_width(DATA_WIDTH)-1:0]  mat [9],
    input  logic signed [DATA_WIDTH-1:0]            vec [3],
    output logic                                    out_valid,
    output logic signed [acc_width(DATA_WIDTH)-1:0] acc [3]
);

    localparam int AW = acc_width(DATA_WIDTH);

    logic                 v3_reg;
    logic                 v4_reg;
    logic signed [AW-1:0] prod_reg [9];
    logic signed [AW-1:0] prod_next [9];
    logic signed [AW-1:0] acc_reg [3];
    logic signed [AW-1:0] acc_next [3];

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                prod_next[3 * r + c] = mat[3 * r + c] * vec[c];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            acc_next[r] = prod_reg[3 * r] + prod_reg[3 * r + 1] + prod_reg[3 * r + 2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= in_valid;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            prod_reg <= prod_next;
        end
        if (v3_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign out_valid = v4_reg;
    assign acc       = acc_reg;

endmodule

`default_nettype wire

### hdl/qrv_round.sv
// ----------------------------------------------------------------------------
// qrv_round
// Stage five: round half up, drop the fraction bits, saturate, flag clipping.
// ----------------------------------------------------------------------------
`default_nettype none

module qrv_round
    import qrv_pkg::*;
#(
    parameter int DATA_WIDTH = 16,
    parameter int FRAC_BITS  = 14
)(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    input  logic signed [acc_width(DATA_WIDTH)-1:0] acc [3],
    output logic                                    out_valid,
    output logic signed [DATA_WIDTH-1:0]            rot [3],
    output logic                                    sat
);

    localparam int RW = rnd_width(DATA_WIDTH, FRAC_BITS);
    localparam int SH = 2 * FRAC_BITS;

    localparam logic signed [RW-1:0] HALF = RW'(1) <<< (SH - 1);
    localparam logic signed [RW-1:0] MAXV = RW'((longint'(1) <<< (DATA_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] MINV = ~MAXV;

    logic                         done_reg;
    logic signed [DATA_WIDTH-1:0] rot_reg [3];
    logic signed [DATA_WIDTH-1:0] rot_next [3];
    logic                         sat_reg;
    logic                         sat_next;
    logic signed [RW-1:0]         rnd [3];
    logic signed [RW-1:0]         quo [3];
    logic [2:0]                   clip;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rnd[i] = RW'(acc[i]) + HALF;
            quo[i] = rnd[i] >>> SH;
            if (quo[i] > MAXV)
            begin
                clip[i]     = 1'b1;
                rot_next[i] = MAXV[DATA_WIDTH-1:0];
            end
            else if (quo[i] < MINV)
            begin
                clip[i]     = 1'b1;
                rot_next[i] = MINV[DATA_WIDTH-1:0];
            end
            else
            begin
                clip[i]     = 1'b0;
                rot_next[i] = quo[i][DATA_WIDTH-1:0];
            end
        end
        sat_next = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            rot_reg <= rot_next;
            sat_reg <= sat_next;
        end
    end

    assign out_valid = done_reg;
    assign rot       = rot_reg;
    assign sat       = sat_reg;

endmodule

`default_nettype wire

### bench/quaternion_rotate_vector_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_rotate_vector_test
// Drives quaternion/vector requests into the rotation pipeline: directed
// corner cases, then random poses with random gaps, a gap-free stream and
// overdriven inputs that provoke clipping. Every done strobe is compared field
// by field with an in-order queue of rotated vectors predicted in 64-bit
// integer arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_rotate_vector_test;

    localparam int DATA_WIDTH    = 16;
    localparam int FRAC_BITS     = 14;
    localparam int PRODUCT_SHIFT = 2 * FRAC_BITS;
    localparam int IDLE_PERCENT  = 19;
    localparam int DRAIN_CYCLES  = 40;

    localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = 16'sh7fff;
    localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = 16'sh8000;
    localparam logic signed [DATA_WIDTH-1:0] Q_ONE    = 16'sd16384;
    localparam logic signed [DATA_WIDTH-1:0] Q_HALF   = 16'sd8192;
    localparam logic signed [DATA_WIDTH-1:0] Q_COS45  = 16'sd11585;

    typedef logic signed [DATA_WIDTH-1:0] word_t;

    typedef struct packed {
        word_t rx;
        word_t ry;
        word_t rz;
        logic  clipped;
    } rotation_t;

    logic  clk;
    logic  rst_n;
    logic  start;
    logic  busy;
    word_t quat_w;
    word_t quat_x;
    word_t quat_y;
    word_t quat_z;
    word_t vec_x;
    word_t vec_y;
    word_t vec_z;
    logic  done;
    word_t rot_x;
    word_t rot_y;
    word_t rot_z;
    logic  saturated;

    rotation_t rotations_pending[$];
    int        error_count;
    logic      steady_flow;

    quaternion_rotate_vector #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .done      (done),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .saturated (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic word_t round_clip(input longint acc, inout logic clipped);
        longint q;
        q = (acc + (longint'(1) <<< (PRODUCT_SHIFT - 1))) >>> PRODUCT_SHIFT;
        if (q > longint'(WORD_MAX))
        begin
            clipped = 1'b1;
            q = longint'(WORD_MAX);
        end
        else if (q < longint'(WORD_MIN))
        begin
            clipped = 1'b1;
            q = longint'(WORD_MIN);
        end
        return word_t'(q);
    endfunction

    function automatic rotation_t rotate_vector(input word_t w, input word_t x,
                                                input word_t y, input word_t z,
                                                input word_t vx, input word_t vy,
                                                input word_t vz);
        longint    lw, lx, ly, lz;
        longint    ww, xx, yy, zz, wx, wy, wz, xy, xz, yz;
        longint    m00, m01, m02, m10, m11, m12, m20, m21, m22;
        rotation_t r;
        logic      clipped;
        lw = w;
        lx = x;
        ly = y;
        lz = z;
        ww = lw * lw;
        xx = lx * lx;
        yy = ly * ly;
        zz = lz * lz;
        wx = lw * lx;
        wy = lw * ly;
        wz = lw * lz;
        xy = lx * ly;
        xz = lx * lz;
        yz = ly * lz;
        m00 = ww + xx - yy - zz;
        m01 = 2 * (xy - wz);
        m02 = 2 * (wy + xz);
        m10 = 2 * (wz + xy);
        m11 = ww - xx + yy - zz;
        m12 = 2 * (yz - wx);
        m20 = 2 * (xz - wy);
        m21 = 2 * (yz + wx);
        m22 = ww - xx - yy + zz;
        clipped = 1'b0;
        r.rx = round_clip(longint'(vx) * m00 + longint'(vy) * m01 + longint'(vz) * m02,
                          clipped);
        r.ry = round_clip(longint'(vx) * m10 + longint'(vy) * m11 + longint'(vz) * m12,
                          clipped);
        r.rz = round_clip(longint'(vx) * m20 + longint'(vy) * m21 + longint'(vz) * m22,
                          clipped);
        r.clipped = clipped;
        return r;
    endfunction

    function automatic word_t any_word();
        return word_t'($urandom);
    endfunction

    // Components within about one unit of Q1.14.
    function automatic word_t near_unit();
        int v;
        v = int'($urandom_range(0, 32768)) - 16384;
        return word_t'(v);
    endfunction

    task automatic send_request(input word_t w, input word_t x, input word_t y,
                                input word_t z, input word_t vx, input word_t vy,
                                input word_t vz);
        if (!steady_flow)
        begin
            while ($urandom_range(0, 99) < IDLE_PERCENT)
            begin
                start  <= 1'b0;
                quat_w <= any_word();
                quat_x <= any_word();
                quat_y <= any_word();
                quat_z <= any_word();
                vec_x  <= any_word();
                vec_y  <= any_word();
                vec_z  <= any_word();
                @(posedge clk);
            end
        end
        start  <= 1'b1;
        quat_w <= w;
        quat_x <= x;
        quat_y <= y;
        quat_z <= z;
        vec_x  <= vx;
        vec_y  <= vy;
        vec_z  <= vz;
        do
            @(posedge clk);
        while (busy);
        rotations_pending.push_back(rotate_vector(w, x, y, z, vx, vy, vz));
    endtask

    always @(posedge clk)
    begin : result_check
        rotation_t want;
        if (rst_n && done)
        begin
            if (rotations_pending.size() == 0)
            begin
                $error("unexpected result: rot_x %0d rot_y %0d rot_z %0d", rot_x, rot_y,
                       rot_z);
                error_count++;
            end
            else
            begin
                want = rotations_pending.pop_front();
                if (rot_x !== want.rx)
                begin
                    $error("rot_x mismatch: expected %0d, got %0d", want.rx, rot_x);
                    error_count++;
                end
                if (rot_y !== want.ry)
                begin
                    $error("rot_y mismatch: expected %0d, got %0d", want.ry, rot_y);
                    error_count++;
                end
                if (rot_z !== want.rz)
                begin
                    $error("rot_z mismatch: expected %0d, got %0d", want.rz, rot_z);
                    error_count++;
                end
                if (saturated !== want.clipped)
                begin
                    $error("saturated mismatch: expected %0b, got %0b", want.clipped,
                           saturated);
                    error_count++;
                end
            end
        end
    end

    task automatic test_corner_cases();
        steady_flow = 1'b0;
        send_request(Q_ONE, 0, 0, 0, WORD_MAX, WORD_MIN, 16'sd1);
        send_request(Q_ONE, 0, 0, 0, WORD_MIN, WORD_MAX, -16'sd1);
        send_request(0, 0, 0, 0, WORD_MAX, WORD_MAX, WORD_MAX);
        send_request(Q_COS45, Q_COS45, 0, 0, 16'sd1000, 16'sd2000, 16'sd3000);
        send_request(Q_COS45, 0, Q_COS45, 0, 16'sd1000, 16'sd2000, 16'sd3000);
        send_request(Q_COS45, 0, 0, Q_COS45, 16'sd1000, 16'sd2000, 16'sd3000);
        send_request(0, Q_ONE, 0, 0, -16'sd1234, 16'sd4321, WORD_MAX);
        send_request(0, 0, Q_ONE, 0, -16'sd1234, 16'sd4321, WORD_MIN);
        send_request(0, 0, 0, Q_ONE, WORD_MIN, WORD_MIN, WORD_MIN);
        // half-way rounding, up and from below
        send_request(Q_HALF, 0, 0, 0, 16'sd2, 16'sd0, 16'sd0);
        send_request(Q_HALF, 0, 0, 0, -16'sd2, 16'sd0, 16'sd0);
        send_request(Q_HALF, 0, 0, 0, 16'sd1, -16'sd3, 16'sd6);
        send_request(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
        send_request(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send_request(WORD_MIN, 0, 0, 0, WORD_MAX, WORD_MIN, WORD_MAX);
        send_request(WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MIN, WORD_MAX, WORD_MIN);
        send_request(16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd1);
        send_request(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1);
        send_request(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 16'sd8000, -16'sd8000, 16'sd8000);
        send_request(0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random_poses(input int count);
        steady_flow = 1'b0;
        repeat (count)
        begin
            if ($urandom_range(0, 99) < 55)
                send_request(near_unit(), near_unit(), near_unit(), near_unit(),
                             any_word(), any_word(), any_word());
            else
                send_request(any_word(), any_word(), any_word(), any_word(),
                             any_word(), any_word(), any_word());
        end
    endtask

    task automatic test_back_to_back(input int count);
        steady_flow = 1'b1;
        repeat (count)
            send_request(near_unit(), near_unit(), near_unit(), near_unit(),
                         any_word(), any_word(), any_word());
        steady_flow = 1'b0;
    endtask

    task automatic test_clipping(input int count);
        word_t big;
        steady_flow = 1'b0;
        repeat (count)
        begin
            big = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
            send_request(any_word(), any_word(), $urandom_range(0, 1) ? big : any_word(),
                         any_word(), big, $urandom_range(0, 1) ? big : any_word(),
                         any_word());
        end
    endtask

    initial
    begin
        int waited;
        error_count = 0;
        steady_flow = 1'b0;
        rst_n  <= 1'b0;
        start  <= 1'b0;
        quat_w <= '0;
        quat_x <= '0;
        quat_y <= '0;
        quat_z <= '0;
        vec_x  <= '0;
        vec_y  <= '0;
        vec_z  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_cases();
        test_random_poses(1000);
        test_back_to_back(500);
        test_clipping(330);

        start <= 1'b0;
        waited = 0;
        while (rotations_pending.size() != 0 && waited < DRAIN_CYCLES)
        begin
            @(posedge clk);
            waited++;
        end
        if (rotations_pending.size() != 0)
        begin
            $error("%0d results never arrived", rotations_pending.size());
            error_count++;
        end
        repeat (10) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

### files.f
+incdir+hdl
hdl/qrv_pkg.sv
hdl/qrv_matrix.sv
hdl/qrv_apply.sv
hdl/qrv_round.sv
hdl/quaternion_rotate_vector.sv
bench/quaternion_rotate_vector_test.sv
